### hdl/bfsa_pkg.sv
// Shared types, constants and codes for the best-fit segment allocator.
// Used by the handle cell, the segment cell and the top level; no dependencies.
`default_nettype none
package bfsa_pkg;

   localparam int MAX_HANDLES  = 64;
   localparam int MAX_SEGMENTS = 65;
   localparam int ADDR_BITS    = 32;
   localparam int KEY_BITS     = 32;
   localparam int HIDX_W       = $clog2(MAX_HANDLES);
   localparam int SIDX_W       = $clog2(MAX_SEGMENTS);

   typedef logic [ADDR_BITS-1:0] addr_type;
   typedef logic [KEY_BITS-1:0]  key_type;
   typedef logic [HIDX_W-1:0]    hidx_type;
   typedef logic [SIDX_W-1:0]    sidx_type;

   typedef enum logic [1:0] {
      FN_ALLOC  = 2'd0,
      FN_FREE   = 2'd1,
      FN_RESIZE = 2'd2
   } func_type;

   typedef enum logic [3:0] {
      STAT_OK         = 4'd0,
      STAT_NOMEM      = 4'd1,
      STAT_DUP        = 4'd2,
      STAT_NOCONT     = 4'd3,
      STAT_UNKNOWN    = 4'd4,
      STAT_BELOW_USED = 4'd5,
      STAT_BELOW_HW   = 4'd6,
      STAT_FULL       = 4'd7,
      STAT_ZERO       = 4'd8
   } stat_type;

   typedef enum logic {
      CSR_ALIGN    = 1'b0,
      CSR_CAPACITY = 1'b1
   } csr_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_HSCAN,
      ST_SSCAN
   } state_type;

   // Running result handed from handle cell to handle cell.
   typedef struct packed {
      logic     tok;
      logic     m_found;
      hidx_type m_idx;
      addr_type m_start;
      addr_type m_len;
      logic     f_found;
      hidx_type f_idx;
   } hcar_type;

   // Write to one handle cell.
   typedef struct packed {
      logic     en;
      hidx_type idx;
      logic     valid;
      key_type  key;
      addr_type start;
      addr_type len;
   } hwr_type;

   // Running result handed from segment cell to segment cell.
   typedef struct packed {
      logic     tok;
      logic     b_found;
      sidx_type b_idx;
      addr_type b_start;
      addr_type b_len;
      logic     l_found;
      sidx_type l_idx;
      addr_type l_start;
      addr_type l_len;
      logic     r_found;
      sidx_type r_idx;
      addr_type r_len;
      logic     s_found;
      sidx_type s_idx;
   } scar_type;

   // Search targets broadcast to all segment cells.
   typedef struct packed {
      addr_type size;
      addr_type lt;
      addr_type rt;
   } stgt_type;

   // Write to one segment cell; a zero length leaves the entry invalid.
   typedef struct packed {
      logic     en;
      sidx_type idx;
      addr_type start;
      addr_type len;
   } swr_type;

endpackage
`default_nettype wire

### hdl/bfsa_hcell.sv
// One handle table entry with its stage of the handle search chain.
// Depends on bfsa_pkg.
`default_nettype none
module bfsa_hcell (
   input  logic               clock,
   input  logic               reset,
   input  bfsa_pkg::hidx_type my_idx,
   input  logic               clr,
   input  bfsa_pkg::hwr_type  wr,
   input  bfsa_pkg::key_type  tkey,
   input  bfsa_pkg::hcar_type cin,
   output bfsa_pkg::hcar_type cout
);

   logic               valid_ff;
   bfsa_pkg::key_type  key_ff;
   bfsa_pkg::addr_type start_ff;
   bfsa_pkg::addr_type len_ff;
   bfsa_pkg::hcar_type car_ff;
   bfsa_pkg::hcar_type car_in;
   logic               hit;

   assign hit = wr.en && (wr.idx == my_idx);

   // Entry storage.
   always_ff @(posedge clock) begin
      if (reset || clr) begin
         valid_ff <= 1'b0;
      end else if (hit) begin
         valid_ff <= wr.valid;
      end
      if (hit) begin
         key_ff   <= wr.key;
         start_ff <= wr.start;
         len_ff   <= wr.len;
      end
   end

   // First matching key and first free entry win.
   always_comb begin
      car_in = cin;
      if (valid_ff && (key_ff == tkey) && !cin.m_found) begin
         car_in.m_found = 1'b1;
         car_in.m_idx   = my_idx;
         car_in.m_start = start_ff;
         car_in.m_len   = len_ff;
      end
      if (!valid_ff && !cin.f_found) begin
         car_in.f_found = 1'b1;
         car_in.f_idx   = my_idx;
      end
   end

   // The word moves one cell per cycle and is held once it has passed.
   always_ff @(posedge clock) begin
      if (reset) begin
         car_ff.tok <= 1'b0;
      end else if (cin.tok) begin
         car_ff <= car_in;
      end else begin
         car_ff.tok <= 1'b0;
      end
   end

   assign cout = car_ff;

endmodule
`default_nettype wire

### hdl/bfsa_scell.sv
// One free segment entry with its stage of the segment search chain.
// Depends on bfsa_pkg.
`default_nettype none
module bfsa_scell (
   input  logic               clock,
   input  logic               reset,
   input  bfsa_pkg::sidx_type my_idx,
   input  logic               clr,
   input  bfsa_pkg::addr_type clr_len,
   input  bfsa_pkg::swr_type  wa,
   input  bfsa_pkg::swr_type  wb,
   input  bfsa_pkg::stgt_type tgt,
   input  bfsa_pkg::scar_type cin,
   output bfsa_pkg::scar_type cout
);

   logic               valid_ff;
   bfsa_pkg::addr_type start_ff;
   bfsa_pkg::addr_type len_ff;
   bfsa_pkg::addr_type seg_end;
   bfsa_pkg::scar_type car_ff;
   bfsa_pkg::scar_type car_in;
   logic               hit_a;
   logic               hit_b;
   logic               first;

   assign hit_a   = wa.en && (wa.idx == my_idx);
   assign hit_b   = wb.en && (wb.idx == my_idx);
   assign first   = (my_idx == '0);
   assign seg_end = start_ff + len_ff;

   // Entry storage; reinit leaves one segment over the whole range in cell zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (clr) begin
         valid_ff <= first && (clr_len != '0);
      end else if (hit_a) begin
         valid_ff <= (wa.len != '0);
      end else if (hit_b) begin
         valid_ff <= (wb.len != '0);
      end
      if (clr) begin
         start_ff <= '0;
         len_ff   <= clr_len;
      end else if (hit_a) begin
         start_ff <= wa.start;
         len_ff   <= wa.len;
      end else if (hit_b) begin
         start_ff <= wb.start;
         len_ff   <= wb.len;
      end
   end

   // Best fit, left and right neighbors, and first empty slot.
   always_comb begin
      car_in = cin;
      if (valid_ff && (len_ff >= tgt.size) &&
          (!cin.b_found || (len_ff < cin.b_len) ||
           ((len_ff == cin.b_len) && (start_ff < cin.b_start)))) begin
         car_in.b_found = 1'b1;
         car_in.b_idx   = my_idx;
         car_in.b_start = start_ff;
         car_in.b_len   = len_ff;
      end
      if (valid_ff && (seg_end == tgt.lt)) begin
         car_in.l_found = 1'b1;
         car_in.l_idx   = my_idx;
         car_in.l_start = start_ff;
         car_in.l_len   = len_ff;
      end
      if (valid_ff && (start_ff == tgt.rt)) begin
         car_in.r_found = 1'b1;
         car_in.r_idx   = my_idx;
         car_in.r_len   = len_ff;
      end
      if (!valid_ff && !cin.s_found) begin
         car_in.s_found = 1'b1;
         car_in.s_idx   = my_idx;
      end
   end

   // The word moves one cell per cycle and is held once it has passed.
   always_ff @(posedge clock) begin
      if (reset) begin
         car_ff.tok <= 1'b0;
      end else if (cin.tok) begin
         car_ff <= car_in;
      end else begin
         car_ff.tok <= 1'b0;
      end
   end

   assign cout = car_ff;

endmodule
`default_nettype wire

### hdl/best_fit_segment_allocator_unit.sv
// Top level of the best-fit segment allocator: control, registers and cell chains.
// Depends on bfsa_pkg, bfsa_hcell and bfsa_scell.
//
//   channel   ports                                    handshake
//   request   start, req_func, req_handle, req_amount  start & !busy
//   response  rsp_valid, rsp_status, rsp_offset, ...   rsp_valid, one cycle
//   csr       csr_wr_en, csr_index, csr_data           csr_wr_en
//
// After the accepting edge the search word walks the handle chain and then
// the segment chain one cell per cycle, and the response word follows. busy is
// high during that time, so the next word is taken at the earliest at the edge
// that ends the response cycle.
// Reset and a capacity write while idle reinitialize the tables.
// The response is shown for one cycle; the receiver cannot stall it.
`default_nettype none
module best_fit_segment_allocator_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_func,
   input  logic [31:0] req_handle,
   input  logic [31:0] req_amount,
   output logic        rsp_valid,
   output logic [3:0]  rsp_status,
   output logic [31:0] rsp_offset,
   output logic [31:0] rsp_granted_size,
   output logic [31:0] rsp_free_total,
   output logic [31:0] rsp_water_mark,
   input  logic        csr_wr_en,
   input  logic        csr_index,
   input  logic [31:0] csr_data
);

   localparam int AB = bfsa_pkg::ADDR_BITS;

   bfsa_pkg::state_type state_ff, state_in;
   logic [4:0]          align_ff;
   bfsa_pkg::addr_type  ts_ff, ts_in, tf_ff, tf_in, hw_ff, hw_in;
   logic [1:0]          func_ff;
   bfsa_pkg::key_type   key_ff;
   bfsa_pkg::addr_type  amt_ff, size_ff;
   logic                nomem_ff;
   logic                hlaunch_ff, hlaunch_in, slaunch_ff, slaunch_in;
   bfsa_pkg::stgt_type  tgt_ff, tgt_in;
   logic                rsp_valid_ff, rsp_valid_in;
   bfsa_pkg::stat_type  status_ff, status_in;
   bfsa_pkg::addr_type  offset_ff, offset_in, gsize_ff, gsize_in;

   bfsa_pkg::hcar_type  hc [bfsa_pkg::MAX_HANDLES+1];
   bfsa_pkg::scar_type  sc [bfsa_pkg::MAX_SEGMENTS+1];
   bfsa_pkg::hcar_type  hres;
   bfsa_pkg::scar_type  sres;
   bfsa_pkg::hwr_type   hwr;
   bfsa_pkg::swr_type   swa, swb;
   logic                clr;
   bfsa_pkg::addr_type  clr_len;

   logic                accept;
   bfsa_pkg::addr_type  lowmask, al, req_rem, csr_round;
   logic [AB:0]         req_sz;
   bfsa_pkg::addr_type  a_end, f_end, ns, used, delta, nl;
   logic                grow;

   assign accept  = start && !busy;
   assign busy    = (state_ff != bfsa_pkg::ST_IDLE);
   assign lowmask = ~({AB{1'b1}} << align_ff);
   assign al      = bfsa_pkg::addr_type'(1) << align_ff;
   assign req_rem = req_amount & lowmask;
   assign req_sz  = {1'b0, req_amount & ~lowmask} +
                    {1'b0, ((req_rem != '0) ? al : bfsa_pkg::addr_type'(0))};
   assign csr_round = csr_data & ~lowmask;

   // Cell chains; the token is the leading field of each chain word.
   assign hc[0] = {hlaunch_ff, {($bits(bfsa_pkg::hcar_type) - 1){1'b0}}};
   assign sc[0] = {slaunch_ff, {($bits(bfsa_pkg::scar_type) - 1){1'b0}}};

   for (genvar gi = 0; gi < bfsa_pkg::MAX_HANDLES; gi++) begin : g_hcell
      bfsa_hcell u_hcell (
         .clock  (clock),
         .reset  (reset),
         .my_idx (bfsa_pkg::hidx_type'(gi)),
         .clr    (clr),
         .wr     (hwr),
         .tkey   (key_ff),
         .cin    (hc[gi]),
         .cout   (hc[gi+1])
      );
   end

   for (genvar gs = 0; gs < bfsa_pkg::MAX_SEGMENTS; gs++) begin : g_scell
      bfsa_scell u_scell (
         .clock   (clock),
         .reset   (reset),
         .my_idx  (bfsa_pkg::sidx_type'(gs)),
         .clr     (clr),
         .clr_len (clr_len),
         .wa      (swa),
         .wb      (swb),
         .tgt     (tgt_ff),
         .cin     (sc[gs]),
         .cout    (sc[gs+1])
      );
   end

   assign hres = hc[bfsa_pkg::MAX_HANDLES];
   assign sres = sc[bfsa_pkg::MAX_SEGMENTS];

   // State register and architectural registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bfsa_pkg::ST_IDLE;
         align_ff     <= '0;
         ts_ff        <= '0;
         tf_ff        <= '0;
         hw_ff        <= '0;
         hlaunch_ff   <= 1'b0;
         slaunch_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ts_ff        <= ts_in;
         tf_ff        <= tf_in;
         hw_ff        <= hw_in;
         hlaunch_ff   <= hlaunch_in;
         slaunch_ff   <= slaunch_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en && (csr_index == bfsa_pkg::CSR_ALIGN)) begin
            align_ff <= csr_data[4:0];
         end
      end
      tgt_ff    <= tgt_in;
      status_ff <= status_in;
      offset_ff <= offset_in;
      gsize_ff  <= gsize_in;
      if (accept) begin
         func_ff  <= req_func;
         key_ff   <= req_handle;
         amt_ff   <= req_amount;
         size_ff  <= req_sz[AB-1:0];
         nomem_ff <= req_sz[AB];
      end
   end

   // Next state, table updates and the response.
   always_comb begin
      state_in     = state_ff;
      ts_in        = ts_ff;
      tf_in        = tf_ff;
      hw_in        = hw_ff;
      hlaunch_in   = 1'b0;
      slaunch_in   = 1'b0;
      tgt_in       = tgt_ff;
      rsp_valid_in = 1'b0;
      status_in    = status_ff;
      offset_in    = offset_ff;
      gsize_in     = gsize_ff;
      hwr          = '0;
      swa          = '0;
      swb          = '0;
      clr          = reset;
      clr_len      = '0;
      a_end        = sres.b_start + size_ff;
      f_end        = hres.m_start + hres.m_len;
      ns           = amt_ff & ~lowmask;
      used         = ts_ff - tf_ff;
      grow         = (ns > ts_ff);
      delta        = grow ? (ns - ts_ff) : (ts_ff - ns);
      nl           = grow ? (sres.l_len + delta) :
                     ((delta <= sres.l_len) ? (sres.l_len - delta) : '0);

      unique case (state_ff)
         bfsa_pkg::ST_IDLE: begin
            if (csr_wr_en && (csr_index == bfsa_pkg::CSR_CAPACITY)) begin
               clr     = 1'b1;
               clr_len = csr_round;
               ts_in   = csr_round;
               tf_in   = csr_round;
               hw_in   = '0;
            end
            if (accept) begin
               hlaunch_in = 1'b1;
               state_in   = bfsa_pkg::ST_HSCAN;
            end
         end
         bfsa_pkg::ST_HSCAN: begin
            if (hres.tok) begin
               tgt_in.size = size_ff;
               tgt_in.lt   = (func_ff == bfsa_pkg::FN_FREE) ? hres.m_start : ts_ff;
               tgt_in.rt   = f_end;
               slaunch_in  = 1'b1;
               state_in    = bfsa_pkg::ST_SSCAN;
            end
         end
         bfsa_pkg::ST_SSCAN: begin
            if (sres.tok) begin
               state_in     = bfsa_pkg::ST_IDLE;
               rsp_valid_in = 1'b1;
               status_in    = bfsa_pkg::STAT_OK;
               offset_in    = '0;
               gsize_in     = '0;
               unique case (func_ff)
                  bfsa_pkg::FN_ALLOC: begin
                     if (nomem_ff || (tf_ff < size_ff)) begin
                        status_in = bfsa_pkg::STAT_NOMEM;
                     end else if (hres.m_found) begin
                        status_in = bfsa_pkg::STAT_DUP;
                     end else if (!sres.b_found) begin
                        status_in = bfsa_pkg::STAT_NOCONT;
                     end else if (size_ff == '0) begin
                        status_in = bfsa_pkg::STAT_ZERO;
                     end else if (!hres.f_found) begin
                        status_in = bfsa_pkg::STAT_FULL;
                     end else begin
                        tf_in = tf_ff - size_ff;
                        if (hw_ff < a_end) begin
                           hw_in = a_end;
                        end
                        swa.en    = 1'b1;
                        swa.idx   = sres.b_idx;
                        swa.start = a_end;
                        swa.len   = sres.b_len - size_ff;
                        hwr.en    = 1'b1;
                        hwr.idx   = hres.f_idx;
                        hwr.valid = 1'b1;
                        hwr.key   = key_ff;
                        hwr.start = sres.b_start;
                        hwr.len   = size_ff;
                        offset_in = sres.b_start;
                        gsize_in  = size_ff;
                     end
                  end
                  bfsa_pkg::FN_FREE: begin
                     if (!hres.m_found) begin
                        status_in = bfsa_pkg::STAT_UNKNOWN;
                     end else if (!sres.l_found && !sres.r_found && !sres.s_found) begin
                        status_in = bfsa_pkg::STAT_FULL;
                     end else begin
                        hwr.en    = 1'b1;
                        hwr.idx   = hres.m_idx;
                        hwr.valid = 1'b0;
                        tf_in     = tf_ff + hres.m_len;
                        if (f_end == hw_ff) begin
                           hw_in = hres.m_start - (sres.l_found ? sres.l_len : '0);
                        end
                        if (sres.l_found && sres.r_found) begin
                           swa.en    = 1'b1;
                           swa.idx   = sres.r_idx;
                           swa.len   = '0;
                           swb.en    = 1'b1;
                           swb.idx   = sres.l_idx;
                           swb.start = sres.l_start;
                           swb.len   = sres.l_len + hres.m_len + sres.r_len;
                        end else if (sres.l_found) begin
                           swb.en    = 1'b1;
                           swb.idx   = sres.l_idx;
                           swb.start = sres.l_start;
                           swb.len   = sres.l_len + hres.m_len;
                        end else if (sres.r_found) begin
                           swa.en    = 1'b1;
                           swa.idx   = sres.r_idx;
                           swa.start = hres.m_start;
                           swa.len   = hres.m_len + sres.r_len;
                        end else begin
                           swa.en    = 1'b1;
                           swa.idx   = sres.s_idx;
                           swa.start = hres.m_start;
                           swa.len   = hres.m_len;
                        end
                     end
                  end
                  bfsa_pkg::FN_RESIZE: begin
                     if (ns < used) begin
                        status_in = bfsa_pkg::STAT_BELOW_USED;
                     end else if (ns < hw_ff) begin
                        status_in = bfsa_pkg::STAT_BELOW_HW;
                     end else if (ns == ts_ff) begin
                        status_in = bfsa_pkg::STAT_OK;
                     end else if (!sres.l_found && grow && !sres.s_found) begin
                        status_in = bfsa_pkg::STAT_FULL;
                     end else begin
                        if (sres.l_found) begin
                           swa.en    = 1'b1;
                           swa.idx   = sres.l_idx;
                           swa.start = sres.l_start;
                           swa.len   = nl;
                        end else if (grow) begin
                           swa.en    = 1'b1;
                           swa.idx   = sres.s_idx;
                           swa.start = ts_ff;
                           swa.len   = delta;
                        end
                        ts_in = ns;
                        tf_in = grow ? (tf_ff + delta) :
                                ((tf_ff >= delta) ? (tf_ff - delta) : '0);
                     end
                  end
                  default: begin
                     status_in = bfsa_pkg::STAT_OK;
                  end
               endcase
            end
         end
         default: begin
            state_in = bfsa_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_offset       = offset_ff;
   assign rsp_granted_size = gsize_ff;
   assign rsp_free_total   = tf_ff;
   assign rsp_water_mark   = hw_ff;

`ifndef ASSERT_OFF
   // An accepted word starts the search.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy && hlaunch_ff)
      else $error("accepted word did not start the handle search");

   // A response appears only when the block has gone back to idle.
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy && $past(busy))
      else $error("response outside the end of an operation");

   // A failed operation grants nothing.
   a_no_grant: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != bfsa_pkg::STAT_OK) |->
         (rsp_offset == '0) && (rsp_granted_size == '0))
      else $error("grant reported on a failed operation");

   // The segment search launch flag is set only from a completed handle search.
   a_chain_order: assert property (@(posedge clock) disable iff (reset)
      slaunch_ff |-> $past(hres.tok) && $past(state_ff == bfsa_pkg::ST_HSCAN))
      else $error("segment search launched out of order");
`endif

endmodule
`default_nettype wire
